// File: hdl/cts_pkg.sv
// ---------------------------------------------------------------------------
// cts_pkg
// Shared types, constants and helpers for the circle set-point pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package cts_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_LEN         = 30;
    localparam int ADDR_W           = 5;

    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic [31:0]        TWO_PI_Q29  = 32'd3373259426;
    localparam logic [32:0]        SPEED_CAP   = 33'h1_0000_0000;

    localparam logic [2:0] REG_RADIUS  = 3'd0;
    localparam logic [2:0] REG_FREQ    = 3'd1;
    localparam logic [2:0] REG_DUR     = 3'd2;
    localparam logic [2:0] REG_START_X = 3'd3;
    localparam logic [2:0] REG_START_Y = 3'd4;
    localparam logic [2:0] REG_START_Z = 3'd5;

    localparam logic [31:0] ATAN_TURNS [ATAN_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    typedef struct packed {
        logic [30:0]        radius;
        logic [31:0]        freq;
        logic [31:0]        duration;
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] start_z;
        logic [32:0]        speed;
    } t_cfg;

    typedef struct packed {
        logic        done;
        logic        ramp;
        logic [15:0] k;
    } t_side;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hdl/cts_regs.sv
// ---------------------------------------------------------------------------
// cts_regs
// APB register file and the derived speed 2*pi*f*r, worked out over three
// registered steps after each write.
// ---------------------------------------------------------------------------
`default_nettype none

module cts_regs
    import cts_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    logic [30:0] r_radius;
    logic [31:0] r_freq;
    logic [31:0] r_dur;
    logic [31:0] r_sx;
    logic [31:0] r_sy;
    logic [31:0] r_sz;
    logic [62:0] r_fr_prod;
    logic [61:0] r_sp_prod;
    logic        r_cap;
    logic [32:0] r_speed;
    logic [46:0] fr;
    logic [32:0] n_speed;
    logic [32:0] sp_round;
    logic        wr;
    logic [2:0]  idx;

    assign wr     = psel & penable & pwrite;
    assign idx    = paddr[ADDR_W-1:2];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= '0;
            r_freq   <= '0;
            r_dur    <= '0;
            r_sx     <= '0;
            r_sy     <= '0;
            r_sz     <= '0;
        end else if (wr) begin
            case (idx)
                REG_RADIUS:  r_radius <= pwdata[30:0];
                REG_FREQ:    r_freq   <= pwdata;
                REG_DUR:     r_dur    <= pwdata;
                REG_START_X: r_sx     <= pwdata;
                REG_START_Y: r_sy     <= pwdata;
                REG_START_Z: r_sz     <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_RADIUS:  prdata = {1'b0, r_radius};
            REG_FREQ:    prdata = r_freq;
            REG_DUR:     prdata = r_dur;
            REG_START_X: prdata = r_sx;
            REG_START_Y: prdata = r_sy;
            REG_START_Z: prdata = r_sz;
            default:     prdata = '0;
        endcase
    end

    // speed chain
    assign fr       = r_fr_prod[62:16];
    assign sp_round = 33'((r_sp_prod + 62'(1 << 28)) >> 29);
    assign n_speed  = (r_cap || sp_round > SPEED_CAP) ? SPEED_CAP : sp_round;

    always_ff @(posedge i_clk) begin
        r_fr_prod <= 63'(r_freq) * 63'(r_radius);
        r_cap     <= fr >= 47'(1 << 30);
        r_sp_prod <= 62'(fr[29:0]) * 62'(TWO_PI_Q29);
        r_speed   <= n_speed;
    end

    always_comb begin
        o_cfg.radius   = r_radius;
        o_cfg.freq     = r_freq;
        o_cfg.duration = r_dur;
        o_cfg.start_x  = r_sx;
        o_cfg.start_y  = r_sy;
        o_cfg.start_z  = r_sz;
        o_cfg.speed    = r_speed;
    end

endmodule

`default_nettype wire

// File: hdl/cts_cordic.sv
// ---------------------------------------------------------------------------
// cts_cordic
// Pipelined rotation-mode CORDIC: one iteration per stage, quadrant fold
// in front and quadrant restore behind. Carries a side tag along.
// ---------------------------------------------------------------------------
`default_nettype none

module cts_cordic
    import cts_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire logic [31:0]        i_phase,
    input  t_side                   i_side,
    output logic                    o_valid,
    output logic signed [33:0]      o_sin,
    output logic signed [33:0]      o_cos,
    output t_side                   o_side
);

    logic               r_v [CORDIC_STEPS+1];
    logic signed [33:0] r_x [CORDIC_STEPS+1];
    logic signed [33:0] r_y [CORDIC_STEPS+1];
    logic signed [33:0] r_z [CORDIC_STEPS+1];
    logic [1:0]         r_q [CORDIC_STEPS+1];
    t_side              r_s [CORDIC_STEPS+1];

    logic [31:0] pq;
    logic [1:0]  quad;
    logic [31:0] resid;

    assign pq    = i_phase + 32'h2000_0000;
    assign quad  = pq[31:30];
    assign resid = i_phase - {quad, 30'd0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
        r_x[0] <= CORDIC_GAIN;
        r_y[0] <= '0;
        r_z[0] <= 34'(signed'(resid));
        r_q[0] <= quad;
        r_s[0] <= i_side;
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
        logic signed [33:0] dx;
        logic signed [33:0] dy;
        logic signed [33:0] at;
        assign dx = r_y[i] >>> i;
        assign dy = r_x[i] >>> i;
        assign at = 34'(ATAN_TURNS[i]);
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else begin
                r_v[i+1] <= r_v[i];
            end
            if (r_z[i] >= 0) begin
                r_x[i+1] <= r_x[i] - dx;
                r_y[i+1] <= r_y[i] + dy;
                r_z[i+1] <= r_z[i] - at;
            end else begin
                r_x[i+1] <= r_x[i] + dx;
                r_y[i+1] <= r_y[i] - dy;
                r_z[i+1] <= r_z[i] + at;
            end
            r_q[i+1] <= r_q[i];
            r_s[i+1] <= r_s[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_v[CORDIC_STEPS];
        end
        o_side <= r_s[CORDIC_STEPS];
        case (r_q[CORDIC_STEPS])
            2'd0: begin
                o_cos <= r_x[CORDIC_STEPS];
                o_sin <= r_y[CORDIC_STEPS];
            end
            2'd1: begin
                o_cos <= -r_y[CORDIC_STEPS];
                o_sin <= r_x[CORDIC_STEPS];
            end
            2'd2: begin
                o_cos <= -r_x[CORDIC_STEPS];
                o_sin <= -r_y[CORDIC_STEPS];
            end
            default: begin
                o_cos <= r_y[CORDIC_STEPS];
                o_sin <= -r_x[CORDIC_STEPS];
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hdl/circle_trajectory_setpoint_top.sv
// ---------------------------------------------------------------------------
// circle_trajectory_setpoint_top
// Position and velocity set-point on a circle for each time sample.
//
//  channel   handshake                        payload
//  sample    start & !busy                    i_sample_time
//  result    o_valid, one cycle               o_pos_*, o_vel_*, o_finished
//  config    psel & penable & pwrite (APB)    paddr, pwdata, prdata
//
// one sample per clock; each result goes through the
// one-stage-per-iteration cordic pipeline
// busy stays low; the result side cannot stall, so nothing is held back
// synchronous active-low reset clears valid bits and the config registers
// ---------------------------------------------------------------------------
`default_nettype none

module circle_trajectory_setpoint_top
    import cts_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [31:0]       i_sample_time,
    output logic                   o_valid,
    output logic signed [31:0]     o_pos_x,
    output logic signed [31:0]     o_pos_y,
    output logic signed [31:0]     o_pos_z,
    output logic signed [31:0]     o_vel_x,
    output logic signed [31:0]     o_vel_y,
    output logic signed [31:0]     o_vel_z,
    output logic                   o_finished,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready
);

    localparam int LAT = CORDIC_STEPS + 9;

    t_cfg cfg;

    cts_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign busy = 1'b0;

    // stage 1: input
    logic        r1_v;
    logic [31:0] r1_t;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= start & ~busy;
        end
        r1_t <= i_sample_time;
    end

    // stage 2: clamp and ramp select
    logic        r2_v;
    logic [31:0] r2_tt;
    t_side       r2_s;
    t_side       n2_s;
    logic [32:0] t_end;
    logic [31:0] rem;
    assign t_end = {1'b0, r1_t} + 33'h1_0000;
    assign rem   = cfg.duration - r1_t;
    always_comb begin
        n2_s.done = r1_t > cfg.duration;
        if (r1_t[31:16] == '0) begin
            n2_s.ramp = 1'b1;
            n2_s.k    = r1_t[15:0];
        end else begin
            n2_s.ramp = t_end > {1'b0, cfg.duration};
            n2_s.k    = rem[15:0];
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
        r2_tt <= n2_s.done ? cfg.duration : r1_t;
        r2_s  <= n2_s;
    end

    // stage 3: phase in turns
    logic        r3_v;
    logic [31:0] r3_ph;
    t_side       r3_s;
    logic [63:0] ph_prod;
    assign ph_prod = 64'(cfg.freq) * 64'(r2_tt);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else begin
            r3_v <= r2_v;
        end
        r3_ph <= ph_prod[31:0];
        r3_s  <= r2_s;
    end

    logic               c_v;
    logic signed [33:0] c_sin;
    logic signed [33:0] c_cos;
    t_side              c_s;

    cts_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r3_v),
        .i_phase (r3_ph),
        .i_side  (r3_s),
        .o_valid (c_v),
        .o_sin   (c_sin),
        .o_cos   (c_cos),
        .o_side  (c_s)
    );

    // stage 6: products
    logic               r6_v;
    t_side              r6_s;
    logic signed [65:0] r6_rs;
    logic signed [65:0] r6_rc;
    logic signed [67:0] r6_vx;
    logic signed [67:0] r6_vy;
    logic signed [33:0] rad_s;
    logic signed [33:0] spd_s;
    assign rad_s = signed'({3'd0, cfg.radius});
    assign spd_s = signed'({1'b0, cfg.speed});
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else begin
            r6_v <= c_v;
        end
        r6_s  <= c_s;
        r6_rs <= 66'(rad_s) * 66'(c_sin);
        r6_rc <= 66'(rad_s) * 66'(c_cos);
        r6_vx <= 68'(spd_s) * 68'(c_cos);
        r6_vy <= 68'(spd_s) * 68'(c_sin);
    end

    // stage 7: position sums and rounded velocity
    localparam logic signed [65:0] HALF_P = 66'sd1 <<< 29;
    localparam logic signed [67:0] HALF_V = 68'sd1 <<< 29;
    logic               r7_v;
    t_side              r7_s;
    logic signed [37:0] r7_px;
    logic signed [37:0] r7_py;
    logic signed [37:0] r7_vx;
    logic signed [37:0] r7_vy;
    logic signed [65:0] rs_r;
    logic signed [65:0] rc_r;
    logic signed [67:0] vx_r;
    logic signed [67:0] vy_r;
    assign rs_r = (r6_rs + HALF_P) >>> 30;
    assign rc_r = (r6_rc + HALF_P) >>> 30;
    assign vx_r = (r6_vx + HALF_V) >>> 30;
    assign vy_r = (r6_vy + HALF_V) >>> 30;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_v <= 1'b0;
        end else begin
            r7_v <= r6_v;
        end
        r7_s  <= r6_s;
        r7_px <= 38'(cfg.start_x) + rs_r[37:0];
        r7_py <= 38'(cfg.start_y) + 38'(rad_s) - rc_r[37:0];
        r7_vx <= vx_r[37:0];
        r7_vy <= vy_r[37:0];
    end

    // stage 8: ramp products
    logic               r8_v;
    t_side              r8_s;
    logic signed [37:0] r8_px;
    logic signed [37:0] r8_py;
    logic signed [54:0] r8_vx;
    logic signed [54:0] r8_vy;
    logic signed [16:0] k_s;
    assign k_s = signed'({1'b0, r7_s.k});
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_v <= 1'b0;
        end else begin
            r8_v <= r7_v;
        end
        r8_s  <= r7_s;
        r8_px <= r7_px;
        r8_py <= r7_py;
        if (r7_s.ramp) begin
            r8_vx <= 55'(r7_vx) * 55'(k_s);
            r8_vy <= 55'(r7_vy) * 55'(k_s);
        end else begin
            r8_vx <= 55'(r7_vx);
            r8_vy <= 55'(r7_vy);
        end
    end

    // stage 9: round, saturate, output
    localparam logic signed [54:0] HALF_K = 55'sd1 <<< 15;
    logic signed [54:0] vx_f;
    logic signed [54:0] vy_f;
    assign vx_f = r8_s.ramp ? (r8_vx + HALF_K) >>> 16 : r8_vx;
    assign vy_f = r8_s.ramp ? (r8_vy + HALF_K) >>> 16 : r8_vy;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r8_v;
        end
        o_pos_x    <= sat32(64'(r8_px));
        o_pos_y    <= sat32(64'(r8_py));
        o_pos_z    <= cfg.start_z;
        o_vel_x    <= r8_s.done ? '0 : sat32(64'(vx_f));
        o_vel_y    <= r8_s.done ? '0 : sat32(64'(vy_f));
        o_vel_z    <= '0;
        o_finished <= r8_s.done;
    end

`ifndef SYNTH
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_valid)
        else $error("result beat missing after sample beat");
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r8_v))
        else $error("result beat without pipeline item");
    a_held_vel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_finished) |-> (o_vel_x == 0 && o_vel_y == 0))
        else $error("velocity not zero past duration");
    a_cordic_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r3_v |-> ##(CORDIC_STEPS + 2) c_v)
        else $error("cordic lost a beat");
`endif

endmodule

`default_nettype wire
